@@ rtl/core/png_stored_block_encoder_top_assert.svh @@
// Assertion macros for the PNG stored-block encoder checker
`ifndef PNG_STORED_BLOCK_ENCODER_TOP_ASSERT_SVH
`define PNG_STORED_BLOCK_ENCODER_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PNGSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define PNGSE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/core/pngse_pkg.sv @@
// Shared constants, types and functions of the PNG stored-block encoder
package pngse_pkg;

  localparam int unsigned CfgW = 14;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_BLK = 2'd1;
  localparam logic [1:0] PH_PIX = 2'd2;
  localparam logic [1:0] PH_TRL = 2'd3;

  localparam logic [5:0] HDR_LAST = 6'd42;
  localparam logic [5:0] BLK_LAST = 6'd5;
  localparam logic [5:0] TRL_LAST = 6'd19;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] IEND_CRC = 32'hAE426082;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  typedef struct packed {
    logic       emit;
    logic       load_pix;
    logic [1:0] phase;
    logic [5:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic header_sent;
    logic row_start;
    logic img_end;
  } status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] adler_mod(input logic [16:0] s);
    logic [16:0] t;
    t = (s >= ADLER_MOD) ? (s - ADLER_MOD) : s;
    return t[15:0];
  endfunction

endpackage

@@ rtl/core/png_stored_block_encoder_top.sv @@
// Top level of the PNG stored-block encoder
//   channel | direction | handshake               | payload
//   input   | in        | in_valid_i / in_stall_o   | pixel_byte_i
//   output  | out       | out_valid_o / out_stall_i | out_byte_o, run_last_o, file_last_o
//   config  | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
// While an item runs and the output is not stalled, one output byte per cycle. An item causes
// 1 byte for a plain pixel, plus 6 at a row start, 43 at file start, 20 at image end.
// The input is taken in the cycle after the previous item's last byte enters the output register.
// Output stall holds the sequencer; reset is asynchronous and clears all control state.
module png_stored_block_encoder_top import pngse_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      pixel_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            file_last_o
);

  cmd_t    cmd;
  status_t status;

  pngse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pngse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pixel_byte_i(pixel_byte_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .file_last_o (file_last_o)
  );

endmodule

@@ rtl/core/pngse_ctrl.sv @@
// Sequencer that walks the header, block, pixel and trailer bytes that an item causes
module pngse_ctrl import pngse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_BLK  = 3'd2;
  localparam logic [2:0] ST_PIX  = 3'd3;
  localparam logic [2:0] ST_TRL  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] idx_q, idx_d;
  logic       accept;
  logic       step;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign step       = (state_q != ST_IDLE) && status_i.out_free;

  always_comb begin
    cmd_o.emit     = step;
    cmd_o.load_pix = accept;
    cmd_o.idx      = idx_q;
    cmd_o.phase    = PH_HDR;
    state_d        = state_q;
    idx_d          = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          if (!status_i.header_sent) begin
            state_d = ST_HDR;
          end else if (status_i.row_start) begin
            state_d = ST_BLK;
          end else begin
            state_d = ST_PIX;
          end
        end
      end
      ST_HDR: begin
        cmd_o.phase = PH_HDR;
        if (step) begin
          idx_d = idx_q + 6'd1;
          if (idx_q == HDR_LAST) begin
            idx_d   = '0;
            state_d = ST_BLK;
          end
        end
      end
      ST_BLK: begin
        cmd_o.phase = PH_BLK;
        if (step) begin
          idx_d = idx_q + 6'd1;
          if (idx_q == BLK_LAST) begin
            idx_d   = '0;
            state_d = ST_PIX;
          end
        end
      end
      ST_PIX: begin
        cmd_o.phase = PH_PIX;
        if (step) begin
          idx_d   = '0;
          state_d = status_i.img_end ? ST_TRL : ST_IDLE;
        end
      end
      ST_TRL: begin
        cmd_o.phase = PH_TRL;
        if (step) begin
          idx_d = idx_q + 6'd1;
          if (idx_q == TRL_LAST) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ rtl/core/pngse_dp.sv @@
// Datapath: byte select, CRC-32, Adler-32, row counters and output register
module pngse_dp import pngse_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic [7:0]      pixel_byte_i,
  input  cmd_t            cmd_i,
  output status_t         status_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            file_last_o
);

  logic [CfgW-1:0] width_q, height_q, w_eff, h_eff;
  logic [15:0]     row_bytes, blk, nblk;
  logic [30:0]     prod_q;
  logic [31:0]     idat_len, crc_out;
  logic [31:0]     crc_q, crc_d, crc_src;
  logic [15:0]     alow_q, ahigh_q, alow_n, ahigh_n;
  logic [15:0]     bir_q;
  logic [CfgW-1:0] row_q;
  logic            hsent_q;
  logic [7:0]      pix_q, byte_d, feed;
  logic            crc_en, crc_seed, adler_en, row_end, last_row, img_end, rlast_d, flast_d;
  logic            ov_q, rl_q, fl_q;
  logic [7:0]      ob_q;

  assign w_eff     = (width_q == '0) ? CfgW'(1) : width_q;
  assign h_eff     = (height_q == '0) ? CfgW'(1) : height_q;
  assign row_bytes = {w_eff, 2'b00};
  assign blk       = row_bytes + 16'd1;
  assign nblk      = ~blk;
  assign idat_len  = {1'b0, prod_q} + 32'd6;
  assign crc_out   = crc_q ^ 32'hFFFFFFFF;
  assign row_end   = ({1'b0, bir_q} + 17'd1) >= {1'b0, row_bytes};
  assign last_row  = ({1'b0, row_q} + 15'd1) >= {1'b0, h_eff};
  assign img_end   = row_end && last_row;

  assign status_o.out_free    = !ov_q || !out_stall_i;
  assign status_o.header_sent = hsent_q;
  assign status_o.row_start   = (bir_q == '0);
  assign status_o.img_end     = img_end;

  always_comb begin
    byte_d   = 8'h00;
    crc_en   = 1'b0;
    crc_seed = 1'b0;
    adler_en = 1'b0;
    feed     = 8'h00;
    rlast_d  = 1'b0;
    flast_d  = 1'b0;
    unique case (cmd_i.phase)
      PH_HDR: begin
        crc_en   = (cmd_i.idx >= 6'd12 && cmd_i.idx <= 6'd28) || (cmd_i.idx >= 6'd37);
        crc_seed = (cmd_i.idx == 6'd12) || (cmd_i.idx == 6'd37);
        case (cmd_i.idx)
          6'd0:  byte_d = 8'd137;
          6'd1:  byte_d = 8'd80;
          6'd2:  byte_d = 8'd78;
          6'd3:  byte_d = 8'd71;
          6'd4:  byte_d = 8'd13;
          6'd5:  byte_d = 8'd10;
          6'd6:  byte_d = 8'd26;
          6'd7:  byte_d = 8'd10;
          6'd11: byte_d = 8'd13;
          6'd12: byte_d = 8'h49;
          6'd13: byte_d = 8'h48;
          6'd14: byte_d = 8'h44;
          6'd15: byte_d = 8'h52;
          6'd18: byte_d = {2'b00, w_eff[13:8]};
          6'd19: byte_d = w_eff[7:0];
          6'd22: byte_d = {2'b00, h_eff[13:8]};
          6'd23: byte_d = h_eff[7:0];
          6'd24: byte_d = 8'd8;
          6'd25: byte_d = 8'd6;
          6'd29: byte_d = crc_out[31:24];
          6'd30: byte_d = crc_out[23:16];
          6'd31: byte_d = crc_out[15:8];
          6'd32: byte_d = crc_out[7:0];
          6'd33: byte_d = idat_len[31:24];
          6'd34: byte_d = idat_len[23:16];
          6'd35: byte_d = idat_len[15:8];
          6'd36: byte_d = idat_len[7:0];
          6'd37: byte_d = 8'h49;
          6'd38: byte_d = 8'h44;
          6'd39: byte_d = 8'h41;
          6'd40: byte_d = 8'h54;
          6'd41: byte_d = 8'h78;
          6'd42: byte_d = 8'h01;
          default: byte_d = 8'h00;
        endcase
      end
      PH_BLK: begin
        crc_en   = 1'b1;
        adler_en = (cmd_i.idx == BLK_LAST);
        case (cmd_i.idx)
          6'd0:    byte_d = {7'd0, last_row};
          6'd1:    byte_d = blk[7:0];
          6'd2:    byte_d = blk[15:8];
          6'd3:    byte_d = nblk[7:0];
          6'd4:    byte_d = nblk[15:8];
          default: byte_d = 8'h00;
        endcase
      end
      PH_PIX: begin
        crc_en   = 1'b1;
        adler_en = 1'b1;
        feed     = pix_q;
        byte_d   = pix_q;
        rlast_d  = !img_end;
      end
      PH_TRL: begin
        crc_en  = (cmd_i.idx <= 6'd3);
        rlast_d = (cmd_i.idx == TRL_LAST);
        flast_d = (cmd_i.idx == TRL_LAST);
        case (cmd_i.idx)
          6'd0:  byte_d = ahigh_q[15:8];
          6'd1:  byte_d = ahigh_q[7:0];
          6'd2:  byte_d = alow_q[15:8];
          6'd3:  byte_d = alow_q[7:0];
          6'd4:  byte_d = crc_out[31:24];
          6'd5:  byte_d = crc_out[23:16];
          6'd6:  byte_d = crc_out[15:8];
          6'd7:  byte_d = crc_out[7:0];
          6'd12: byte_d = 8'h49;
          6'd13: byte_d = 8'h45;
          6'd14: byte_d = 8'h4E;
          6'd15: byte_d = 8'h44;
          6'd16: byte_d = IEND_CRC[31:24];
          6'd17: byte_d = IEND_CRC[23:16];
          6'd18: byte_d = IEND_CRC[15:8];
          6'd19: byte_d = IEND_CRC[7:0];
          default: byte_d = 8'h00;
        endcase
      end
      default: byte_d = 8'h00;
    endcase
  end

  assign crc_src = crc_seed ? 32'hFFFFFFFF : crc_q;
  assign crc_d   = crc_byte(crc_src, byte_d);
  assign alow_n  = adler_mod({1'b0, alow_q} + {9'd0, feed});
  assign ahigh_n = adler_mod({1'b0, ahigh_q} + {1'b0, alow_n});

  always_ff @(posedge clk_i) begin
    prod_q <= 31'(h_eff * ({1'b0, row_bytes} + 17'd6));
    if (cmd_i.load_pix) begin
      pix_q <= pixel_byte_i;
    end
    if (cmd_i.emit) begin
      ob_q <= byte_d;
      rl_q <= rlast_d;
      fl_q <= flast_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(1);
      height_q <= CfgW'(1);
      crc_q    <= 32'hFFFFFFFF;
      alow_q   <= 16'd1;
      ahigh_q  <= 16'd0;
      bir_q    <= '0;
      row_q    <= '0;
      hsent_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_HEIGHT: height_q <= cfg_wdata_i;
          default:    width_q  <= width_q;
        endcase
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        if (crc_en) begin
          crc_q <= crc_d;
        end
        if (adler_en) begin
          alow_q  <= alow_n;
          ahigh_q <= ahigh_n;
        end
        if (cmd_i.phase == PH_HDR && cmd_i.idx == HDR_LAST) begin
          hsent_q <= 1'b1;
          bir_q   <= '0;
          row_q   <= '0;
        end
        if (cmd_i.phase == PH_PIX) begin
          if (row_end) begin
            bir_q <= '0;
            if (!last_row) begin
              row_q <= row_q + CfgW'(1);
            end
          end else begin
            bir_q <= bir_q + 16'd1;
          end
        end
        if (cmd_i.phase == PH_TRL && cmd_i.idx == TRL_LAST) begin
          crc_q   <= 32'hFFFFFFFF;
          alow_q  <= 16'd1;
          ahigh_q <= 16'd0;
          bir_q   <= '0;
          row_q   <= '0;
          hsent_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign run_last_o  = rl_q;
  assign file_last_o = fl_q;

endmodule

@@ rtl/core/pngse_checker.sv @@
// Port-level checker of the PNG stored-block encoder and its bind
`include "png_stored_block_encoder_top_assert.svh"

module pngse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       file_last_o
);

  `PNGSE_ASSERT(a_file_last_ends_run, !out_valid_o || !file_last_o || run_last_o, "file_last without run_last")
  `PNGSE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted item did not make block busy")
  `PNGSE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(run_last_o), "stalled output item changed")

endmodule

bind png_stored_block_encoder_top pngse_checker u_pngse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o),
  .run_last_o (run_last_o),
  .file_last_o(file_last_o)
);
